FILE: sv/stereo_waveshaper_distortion_top_macros.svh
// Assertion helpers used by the waveshaper control block.
`ifndef STEREO_WAVESHAPER_DISTORTION_TOP_MACROS_SVH
`define STEREO_WAVESHAPER_DISTORTION_TOP_MACROS_SVH

// Checks the consequent in the same cycle as the antecedent.
`define SWD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("waveshaper check failed (same cycle)");

// Checks the consequent in the cycle after the antecedent.
`define SWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("waveshaper check failed (next cycle)");

`endif

FILE: sv/swd_pkg.sv
package swd_pkg;

    // Sample format.
    localparam int SAMPLE_BITS     = 24;
    localparam int FRAC_BITS       = SAMPLE_BITS - 1;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;

    // Configuration registers.
    localparam int DRIVE_W    = 16;
    localparam int MIX_W      = 13;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_HARD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOFT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FOLD   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd3;

    localparam logic signed [DRIVE_W-1:0] DRIVE_RESET = 16'sd0;
    localparam logic [MIX_W-1:0]          WET_RESET   = 13'd2048;
    localparam logic [MODE_W-1:0]         MODE_RESET  = MODE_HARD;

    // Arithmetic widths.
    localparam int DRIVE_SHIFT = 12;
    localparam int DRIVE_UNITY = 1 << DRIVE_SHIFT;
    localparam int GAIN_W      = DRIVE_W + 1;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W;
    localparam int T_W         = PROD_W - DRIVE_SHIFT;
    localparam int C_W         = FRAC_BITS + 2;
    localparam int SQ_W        = 2 * C_W;
    localparam int SOFT_W      = C_W + 2;
    localparam int MIX_SHIFT   = 12;
    localparam int MIX_ONE     = 1 << MIX_SHIFT;
    localparam int MIX_ROUND   = MIX_ONE / 2;
    localparam int XD_W        = SAMPLE_BITS + MIX_W + 1;
    localparam int SUM_W       = T_W + MIX_W + 2;

    localparam longint ONE_VAL = longint'(1) << FRAC_BITS;
    localparam logic signed [T_W-1:0]   T_ONE   = T_W'(ONE_VAL);
    localparam logic signed [T_W-1:0]   T_MONE  = T_W'(-ONE_VAL);
    localparam logic signed [C_W-1:0]   C_ONE   = C_W'(ONE_VAL);
    localparam logic signed [C_W-1:0]   C_MONE  = C_W'(-ONE_VAL);
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(ONE_VAL - 1);
    localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-ONE_VAL);

    // Pipeline depth: six lane stages plus the merged output register.
    localparam int STAGES = 7;

    typedef struct packed {
        logic out;
        logic s6;
        logic s5;
        logic s4;
        logic s3;
        logic s2;
        logic s1;
    } swd_load_t;

    // Sine table contents, built at elaboration with a Q2.30 Taylor series.
    localparam longint ONE_Q30    = longint'(1) << 30;
    localparam longint TWO_PI_Q29 = 64'sd3373259426;

    // Horner divisors (2i)(2i+1) of the series, for i from 1 to 7.
    localparam longint TAYLOR_DIV [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                          64'sd110, 64'sd156, 64'sd210};

    typedef logic signed [C_W-1:0] sine_rom_t [SINE_N];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    kl;
        longint    n;
        longint    g;
        longint    a;
        longint    a2;
        longint    acc;
        longint    s;
        n = longint'(SINE_N);
        for (int k = 0; k < SINE_N; k++) begin
            kl = longint'(k);
            if (kl < n / 4) begin
                g = kl;
            end else if (kl < 3 * (n / 4)) begin
                g = n / 2 - kl;
            end else begin
                g = kl - n;
            end
            a   = (g * TWO_PI_Q29) >>> (SINE_TABLE_BITS - 1);
            a2  = (a * a) >>> 30;
            acc = ONE_Q30;
            for (int i = 7; i >= 1; i--) begin
                acc = ONE_Q30 - (((acc * a2) >>> 30) / TAYLOR_DIV[i - 1]);
            end
            s = (a * acc) >>> 30;
            if (FRAC_BITS <= 30) begin
                s = (s + ((longint'(1) << (30 - FRAC_BITS)) >>> 1)) >>> (30 - FRAC_BITS);
            end else begin
                s = s * (longint'(1) << (FRAC_BITS - 30));
            end
            rom[k] = s[C_W-1:0];
        end
        return rom;
    endfunction

endpackage

FILE: sv/stereo_waveshaper_distortion_top.sv
// Stereo waveshaping distortion. Each transfer on the input channel carries one Q1.23
// sample pair; both channels are processed side by side in identical lanes and come
// out together as one transfer, saturated to Q1.23. The block takes one pair every
// cycle: all seven stages are registered, and each holds its item until the stage
// after it frees up, so a stalled output only blocks input once every stage is full.
// Every lane holds its own 1024 by 25 bit sine ROM, read once per cycle with
// a registered output. Configuration (drive, wet mix, clip mode) is written through a
// simple write port and is expected to change only while no transfer is in flight.
module stereo_waveshaper_distortion_top
    import swd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    logic signed [DRIVE_W-1:0] drive_reg;
    logic [MIX_W-1:0]          wet_reg;
    logic [MODE_W-1:0]         mode_reg;

    logic signed [GAIN_W-1:0]  gain;
    logic [MIX_W-1:0]          wet_eff;
    swd_load_t                 ld;
    logic signed [SUM_W-1:0]   left_sum, right_sum;

    // Register file. Writes to an index beyond the clip mode register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            drive_reg <= DRIVE_RESET;
            wet_reg   <= WET_RESET;
            mode_reg  <= MODE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DRIVE: drive_reg <= cfg_data[DRIVE_W-1:0];
                CFG_WET:   wet_reg   <= cfg_data[MIX_W-1:0];
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                default:   ;
            endcase
        end
    end

    // The gain is one plus the drive, and a wet mix above one acts as fully wet.
    assign gain    = GAIN_W'(drive_reg) + GAIN_W'(DRIVE_UNITY);
    assign wet_eff = (wet_reg > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : wet_reg;

    swd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ld        (ld)
    );

    swd_lane u_lane_left (
        .clk  (clk),
        .ld   (ld),
        .x_in (left_in),
        .gain (gain),
        .wet  (wet_eff),
        .mode (mode_reg),
        .sum  (left_sum)
    );

    swd_lane u_lane_right (
        .clk  (clk),
        .ld   (ld),
        .x_in (right_in),
        .gain (gain),
        .wet  (wet_eff),
        .mode (mode_reg),
        .sum  (right_sum)
    );

    // Both lanes finish in the same cycle and leave as one output transfer.
    swd_merge u_merge (
        .clk       (clk),
        .ld        (ld),
        .left_sum  (left_sum),
        .right_sum (right_sum),
        .left_out  (left_out),
        .right_out (right_out)
    );

endmodule

FILE: sv/swd_ctrl.sv
`include "stereo_waveshaper_distortion_top_macros.svh"

module swd_ctrl
    import swd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output swd_load_t ld
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] upstream;
    logic [STAGES-1:0] ld_vec;
    logic              in_fire;
    logic              out_fire;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign upstream = {valid_reg[STAGES-2:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < STAGES; k++) begin
            ld_vec[k]     = stage_ready[k] && upstream[k];
            valid_next[k] = stage_ready[k] ? upstream[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ld        = swd_load_t'(ld_vec);
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    `SWD_ASSERT_NOW(a_full_stall_blocks, clk, rst_n, (&valid_reg) && !out_ready, !in_ready)
    `SWD_ASSERT_NEXT(a_accept_fills_first, clk, rst_n, in_fire, valid_reg[0])
    `SWD_ASSERT_NOW(a_item_count, clk, rst_n, $past(rst_n), $countones(valid_reg) == $past($countones(valid_reg)) + $past(in_fire) - $past(out_fire))

endmodule

FILE: sv/swd_lane.sv
module swd_lane
    import swd_pkg::*;
(
    input  logic                      clk,
    input  swd_load_t                 ld,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [GAIN_W-1:0]  gain,
    input  logic [MIX_W-1:0]          wet,
    input  logic [MODE_W-1:0]         mode,
    output logic signed [SUM_W-1:0]   sum
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg, x3_reg, x4_reg;
    logic signed [T_W-1:0]         t2_reg, t3_reg, t4_reg;
    logic signed [C_W-1:0]         clip3_reg, clip4_reg;
    logic signed [C_W-1:0]         sq3_reg, cube4_reg;
    logic signed [C_W-1:0]         rom3_reg, rom4_reg;
    logic signed [T_W-1:0]         y5_reg, y5_next;
    logic signed [XD_W-1:0]        xd5_reg, xd5_next;
    logic signed [SUM_W-1:0]       sum6_reg, sum6_next;

    logic signed [PROD_W-1:0] prod;
    logic signed [T_W-1:0]    t2_next;
    logic signed [C_W-1:0]    clip;
    logic signed [SQ_W-1:0]   sq;
    logic signed [SQ_W-1:0]   cube;
    logic signed [SOFT_W-1:0] soft_sum;

    // Drive gain.
    assign prod    = PROD_W'(x1_reg) * PROD_W'(gain);
    assign t2_next = T_W'(prod >>> DRIVE_SHIFT);

    // Clamp to plus or minus one and square for the cubic.
    always_comb
    begin
        if (t2_reg > T_ONE) begin
            clip = C_ONE;
        end else if (t2_reg < T_MONE) begin
            clip = C_MONE;
        end else begin
            clip = t2_reg[C_W-1:0];
        end
    end

    assign sq   = SQ_W'(clip) * SQ_W'(clip);
    assign cube = SQ_W'(sq3_reg) * SQ_W'(clip3_reg);

    assign soft_sum = (SOFT_W'(clip4_reg) <<< 1) + SOFT_W'(clip4_reg) - SOFT_W'(cube4_reg);

    always_comb
    begin
        unique case (mode)
            MODE_HARD:   y5_next = T_W'(clip4_reg);
            MODE_SOFT:   y5_next = T_W'(soft_sum >>> 1);
            MODE_FOLD:   y5_next = T_W'(rom4_reg);
            MODE_BYPASS: y5_next = t4_reg;
            default:     y5_next = t4_reg;
        endcase
    end

    assign xd5_next  = XD_W'(x4_reg) * XD_W'($signed({1'b0, MIX_W'(MIX_ONE) - wet}));
    assign sum6_next = SUM_W'($signed({1'b0, wet})) * SUM_W'(y5_reg)
                     + SUM_W'(xd5_reg) + SUM_W'(MIX_ROUND);

    always_ff @(posedge clk)
    begin
        if (ld.s1) begin
            x1_reg <= x_in;
        end
        if (ld.s2) begin
            x2_reg <= x1_reg;
            t2_reg <= t2_next;
        end
        if (ld.s3) begin
            x3_reg    <= x2_reg;
            t3_reg    <= t2_reg;
            clip3_reg <= clip;
            sq3_reg   <= C_W'(sq >>> FRAC_BITS);
            rom3_reg  <= SINE_ROM[t2_reg[FRAC_BITS-1 -: SINE_TABLE_BITS]];
        end
        if (ld.s4) begin
            x4_reg    <= x3_reg;
            t4_reg    <= t3_reg;
            clip4_reg <= clip3_reg;
            cube4_reg <= C_W'(cube >>> FRAC_BITS);
            rom4_reg  <= rom3_reg;
        end
        if (ld.s5) begin
            y5_reg  <= y5_next;
            xd5_reg <= xd5_next;
        end
        if (ld.s6) begin
            sum6_reg <= sum6_next;
        end
    end

    assign sum = sum6_reg;

endmodule

FILE: sv/swd_merge.sv
module swd_merge
    import swd_pkg::*;
(
    input  logic                          clk,
    input  swd_load_t                     ld,
    input  logic signed [SUM_W-1:0]       left_sum,
    input  logic signed [SUM_W-1:0]       right_sum,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    logic signed [SUM_W-1:0]       left_shift, right_shift;
    logic signed [SAMPLE_BITS-1:0] left_next, right_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;

    assign left_shift  = left_sum >>> MIX_SHIFT;
    assign right_shift = right_sum >>> MIX_SHIFT;

    // Saturate both channels to the sample range.
    always_comb
    begin
        priority if (left_shift > OUT_MAX) begin
            left_next = SAMPLE_BITS'(OUT_MAX);
        end else if (left_shift < OUT_MIN) begin
            left_next = SAMPLE_BITS'(OUT_MIN);
        end else begin
            left_next = left_shift[SAMPLE_BITS-1:0];
        end
        priority if (right_shift > OUT_MAX) begin
            right_next = SAMPLE_BITS'(OUT_MAX);
        end else if (right_shift < OUT_MIN) begin
            right_next = SAMPLE_BITS'(OUT_MIN);
        end else begin
            right_next = right_shift[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.out) begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule
